@@ src/cfq_pkg.sv @@
// Package for the circular FIFO queue: depth, pointer type, operation and
// status codes, beat structs and the controller/datapath command bundle.
// No dependencies.
package cfq_pkg;

  localparam int DEPTH = 8;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_DISP = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    func_t func;
    word_t data_in;
  } in_item_t;

  typedef struct packed {
    status_t status;
    word_t   data_out;
    logic    last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DEQ  = 2'd1,
    S_DISP = 2'd2
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    enq_wr;
    logic    deq_start;
    logic    walk_start;
    logic    walk_step;
    logic    out_load;
    status_t out_status;
    logic    out_from_mem;
    logic    out_last;
  } cfq_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_at_tail;
    logic out_free;
  } cfq_sts_t;

  // Advance a ring pointer with wrap at DEPTH.
  function automatic ptr_t next_slot(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

@@ src/cfq_dp.sv @@
// Datapath of the circular FIFO queue: ring memory, head/tail/walk pointers,
// empty flag and the output register. Depends on cfq_pkg.
module cfq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  cfq_pkg::word_t    wr_data,
  input  cfq_pkg::cfq_cmd_t cmd,
  input  logic              out_stall,
  output cfq_pkg::cfq_sts_t sts,
  output logic              out_valid,
  output cfq_pkg::out_item_t out_data
);

  cfq_pkg::word_t ring_mem [cfq_pkg::DEPTH];
  cfq_pkg::word_t rd_data_r;

  cfq_pkg::ptr_t head_r, head_nxt;
  cfq_pkg::ptr_t tail_r, tail_nxt;
  cfq_pkg::ptr_t walk_r, walk_nxt;
  logic          empty_r, empty_nxt;
  logic          out_valid_r, out_valid_nxt;
  cfq_pkg::out_item_t out_data_r;

  cfq_pkg::ptr_t wr_addr;
  cfq_pkg::ptr_t rd_addr;
  logic          rd_en;

  assign sts.empty        = empty_r;
  assign sts.full         = !empty_r && (cfq_pkg::next_slot(tail_r) == head_r);
  assign sts.walk_at_tail = (walk_r == tail_r);
  assign sts.out_free     = !out_valid_r || !out_stall;

  assign wr_addr = empty_r ? '0 : cfq_pkg::next_slot(tail_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    walk_nxt  = walk_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    if (cmd.enq_wr) begin
      // An empty ring restarts at entry zero.
      head_nxt  = empty_r ? '0 : head_r;
      tail_nxt  = wr_addr;
      empty_nxt = 1'b0;
    end
    if (cmd.deq_start) begin
      rd_en = 1'b1;
      if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else begin
        head_nxt = cfq_pkg::next_slot(head_r);
      end
    end
    if (cmd.walk_start) begin
      rd_en    = 1'b1;
      walk_nxt = head_r;
    end
    if (cmd.walk_step) begin
      rd_en    = 1'b1;
      walk_nxt = cfq_pkg::next_slot(walk_r);
      rd_addr  = walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_wr) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      walk_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      walk_r      <= walk_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status   <= cmd.out_status;
      out_data_r.data_out <= cmd.out_from_mem ? rd_data_r : '0;
      out_data_r.last     <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/cfq_ctrl.sv @@
// Controller of the circular FIFO queue: decodes operations and sequences
// dequeue reads and display walks. Depends on cfq_pkg.
module cfq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cfq_pkg::func_t    in_func,
  input  cfq_pkg::cfq_sts_t sts,
  output logic              in_stall,
  output cfq_pkg::cfq_cmd_t cmd
);

  cfq_pkg::ctrl_state_t state_r, state_nxt;
  logic                 accept;

  assign in_stall = (state_r != cfq_pkg::S_IDLE) || !sts.out_free;
  assign accept   = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfq_pkg::S_IDLE: begin
        if (accept && !sts.empty) begin
          case (in_func)
            cfq_pkg::FN_DEQ:  state_nxt = cfq_pkg::S_DEQ;
            cfq_pkg::FN_DISP: state_nxt = cfq_pkg::S_DISP;
            default:          state_nxt = cfq_pkg::S_IDLE;
          endcase
        end
      end
      cfq_pkg::S_DEQ: begin
        state_nxt = cfq_pkg::S_IDLE;
      end
      cfq_pkg::S_DISP: begin
        if (sts.out_free && sts.walk_at_tail) begin
          state_nxt = cfq_pkg::S_IDLE;
        end
      end
      default: state_nxt = cfq_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd              = '0;
    cmd.out_status   = cfq_pkg::ST_OK;
    cmd.out_last     = 1'b1;
    unique case (state_r)
      cfq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_func)
            cfq_pkg::FN_ENQ: begin
              cmd.enq_wr     = !sts.full;
              cmd.out_load   = 1'b1;
              cmd.out_status = sts.full ? cfq_pkg::ST_OVERFLOW : cfq_pkg::ST_OK;
            end
            cfq_pkg::FN_DEQ: begin
              cmd.deq_start  = !sts.empty;
              cmd.out_load   = sts.empty;
              cmd.out_status = cfq_pkg::ST_EMPTY;
            end
            cfq_pkg::FN_DISP: begin
              cmd.walk_start = !sts.empty;
              cmd.out_load   = sts.empty;
              cmd.out_status = cfq_pkg::ST_EMPTY;
            end
            default: begin
              cmd.out_load = 1'b0;
            end
          endcase
        end
      end
      cfq_pkg::S_DEQ: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
      end
      cfq_pkg::S_DISP: begin
        if (sts.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = sts.walk_at_tail;
          cmd.walk_step    = !sts.walk_at_tail;
        end
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/circular_fifo_queue_top.sv @@
// Top level of the circular FIFO queue: controller plus datapath.
// Depends on cfq_pkg, cfq_ctrl and cfq_dp.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+--------------------------
//   input   | in_valid, in_stall, in_data    | func and data_in
//   output  | out_valid, out_stall, out_data | status, data_out and last
//
// An enqueue, or any operation on an empty ring, is done in S_IDLE, so enqueues
// stream at one per cycle unless the output stalls. A dequeue passes through
// S_DEQ as the ring memory has a registered read port. A display reads each
// entry from head to tail. Synchronous reset empties the ring and drops a
// pending result beat but leaves the ring contents. An output stall holds the
// result beat and the walk, and stalls the input until the output can take more.
module circular_fifo_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfq_pkg::out_item_t out_data
);

  // Command and status bundles between controller and datapath.
  cfq_pkg::cfq_cmd_t cmd;
  cfq_pkg::cfq_sts_t sts;

  cfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  cfq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_data   (in_data.data_in),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_circular_fifo_queue_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for circular_fifo_queue_top. A mirror of the ring
// predicts every result beat, and the output channel is checked in order.
// Depends on cfq_pkg and the RTL of circular_fifo_queue_top.
module tb_circular_fifo_queue_top;

  // The limit leaves a wide margin above the length of the run.
  localparam longint TIMEOUT_NS = 2_000_000;
  // This is how long the receiver holds off during the back-pressure stretch.
  localparam int HOLD_CYCLES = 60;
  // A display walks at most DEPTH entries; the wait also covers the pipeline.
  localparam int DRAIN_CYCLES = cfq_pkg::DEPTH + 12;
  // The block ignores func code 3. A beat with that code produces no result.
  localparam cfq_pkg::func_t FN_UNUSED = cfq_pkg::func_t'(2'd3);

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

  // The ring mirror. It holds its own copy of the queue state and turns each
  // accepted request into the result beats that the block must produce.
  class ring_mirror;
    cfq_pkg::word_t     slots [cfq_pkg::DEPTH];
    cfq_pkg::ptr_t      head;
    cfq_pkg::ptr_t      tail;
    bit                 empty;
    cfq_pkg::out_item_t expected_beats [$];
    int                 mismatches;

    function new();
      head = '0;
      tail = '0;
      empty = 1'b1;
      mismatches = 0;
    endfunction

    function cfq_pkg::ptr_t wrap_inc(cfq_pkg::ptr_t p);
      if (int'(p) == cfq_pkg::DEPTH - 1) begin
        return '0;
      end
      return p + cfq_pkg::ptr_t'(1);
    endfunction

    function void push_beat(cfq_pkg::status_t st, cfq_pkg::word_t val, logic fin);
      cfq_pkg::out_item_t b;
      b.status = st;
      b.data_out = val;
      b.last = fin;
      expected_beats.push_back(b);
    endfunction

    function void take_request(cfq_pkg::in_item_t req);
      cfq_pkg::ptr_t p;
      int            walked;
      case (req.func)
        cfq_pkg::FN_ENQ: begin
          if (empty) begin
            // On an empty ring, both pointers restart at entry zero.
            head = '0;
            tail = '0;
            slots[0] = req.data_in;
            empty = 1'b0;
            push_beat(cfq_pkg::ST_OK, '0, 1'b1);
          end else if (wrap_inc(tail) == head) begin
            push_beat(cfq_pkg::ST_OVERFLOW, '0, 1'b1);
          end else begin
            tail = wrap_inc(tail);
            slots[tail] = req.data_in;
            push_beat(cfq_pkg::ST_OK, '0, 1'b1);
          end
        end
        cfq_pkg::FN_DEQ: begin
          if (empty) begin
            push_beat(cfq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            push_beat(cfq_pkg::ST_OK, slots[head], 1'b1);
            if (head == tail) begin
              head = '0;
              tail = '0;
              empty = 1'b1;
            end else begin
              head = wrap_inc(head);
            end
          end
        end
        cfq_pkg::FN_DISP: begin
          if (empty) begin
            push_beat(cfq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            p = head;
            walked = 0;
            while (p != tail && walked < cfq_pkg::DEPTH - 1) begin
              push_beat(cfq_pkg::ST_OK, slots[p], 1'b0);
              walked++;
              p = wrap_inc(p);
            end
            push_beat(cfq_pkg::ST_OK, slots[p], 1'b1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_beat(cfq_pkg::out_item_t got);
      cfq_pkg::out_item_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: status=%0d data_out=%h last=%0d",
                 $time, got.status, got.data_out, got.last);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.status !== want.status || got.data_out !== want.data_out ||
          got.last !== want.last) begin
        $display("%0t: result mismatch: expected status=%0d data_out=%h last=%0d",
                 $time, want.status, want.data_out, want.last);
        $display("%0t:                  actual   status=%0d data_out=%h last=%0d",
                 $time, got.status, got.data_out, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  cfq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  cfq_pkg::out_item_t out_data;

  ring_mirror book;

  // These settings control idling. The sender leaves a gap before a beat with
  // probability in_gap_pct. The receiver stalls a cycle with probability
  // out_stall_pct.
  int in_gap_pct;
  int out_stall_pct;
  // The main sequence raises hold_req. The receiver process then holds off
  // for a stretch that it counts itself from HOLD_CYCLES.
  bit hold_req;
  // This counts requests the block acts on. Ignored codes are left out.
  int served;

  circular_fifo_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // The receiver drives out_stall at the falling edge. It either follows the
  // random stall rate or sits out a long hold-off, so the block stalls its
  // input.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < out_stall_pct);
      end
    end
  end

  // Result beats are sampled at the rising edge, so the values are those
  // that held just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_beat(out_data);
    end
  end

  // This task offers one request beat and returns once it is accepted. It is
  // entered and left just after a falling edge. So valid gets one assignment
  // per step, and a beat that is followed at once by the next one keeps valid
  // high with no glitch.
  task automatic send_request(cfq_pkg::func_t f, cfq_pkg::word_t d);
    cfq_pkg::in_item_t req;
    req.func = f;
    req.data_in = d;
    while ($urandom_range(99, 0) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    book.take_request(req);
    if (f != FN_UNUSED) served++;
    @(negedge clk);
  endtask

  // Most values are fully random. One in eight is a corner value instead.
  function automatic cfq_pkg::word_t pick_value();
    if ($urandom_range(7, 0) == 0) begin
      case ($urandom_range(3, 0))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // A burst leans toward filling, draining, or a mix. Alternating bursts walk
  // the ring through full, empty and every level in between, with wrap of
  // both pointers.
  task automatic run_burst(int count);
    burst_mode_t    mode;
    int             t_enq;
    int             t_deq;
    int             t_disp;
    int             r;
    cfq_pkg::func_t f;
    mode = burst_mode_t'($urandom_range(2, 0));
    case (mode)
      MODE_FILL: begin
        t_enq = 75; t_deq = 83; t_disp = 98;
      end
      MODE_DRAIN: begin
        t_enq = 12; t_deq = 82; t_disp = 98;
      end
      default: begin
        t_enq = 40; t_deq = 75; t_disp = 97;
      end
    endcase
    repeat (count) begin
      r = $urandom_range(99, 0);
      if (r < t_enq) f = cfq_pkg::FN_ENQ;
      else if (r < t_deq) f = cfq_pkg::FN_DEQ;
      else if (r < t_disp) f = cfq_pkg::FN_DISP;
      else f = FN_UNUSED;
      send_request(f, pick_value());
    end
  endtask

  // One idling phase lasts until about n requests have been acted on.
  task automatic run_phase(int gap_pct, int stall_pct, int n);
    int goal;
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    goal = served + n;
    while (served < goal) begin
      run_burst($urandom_range(14, 4));
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hold_req = 1'b0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    served = 0;
    book = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First come the empty-ring answers and the ignored code.
    send_request(cfq_pkg::FN_DISP, 32'h0);
    send_request(cfq_pkg::FN_DEQ, 32'h0);
    send_request(FN_UNUSED, 32'hffff_ffff);
    // Next, an enqueue to an empty ring and the dequeue of the only entry,
    // which empties the ring again. An underflow follows.
    send_request(cfq_pkg::FN_ENQ, 32'h7fff_ffff);
    send_request(cfq_pkg::FN_DEQ, 32'h0);
    send_request(cfq_pkg::FN_DEQ, 32'h1234_5678);
    // Then the ring is filled to DEPTH entries with the extremes among them.
    // An overflow and a full display, which gives the most beats, follow.
    send_request(cfq_pkg::FN_ENQ, 32'h8000_0000);
    send_request(cfq_pkg::FN_ENQ, 32'hffff_ffff);
    send_request(cfq_pkg::FN_ENQ, 32'h0000_0000);
    for (int i = 3; i < cfq_pkg::DEPTH; i++) begin
      send_request(cfq_pkg::FN_ENQ, cfq_pkg::word_t'(i * 32'h1111_1111));
    end
    send_request(cfq_pkg::FN_ENQ, 32'h5a5a_5a5a);
    send_request(cfq_pkg::FN_DISP, 32'hffff_ffff);
    // A dequeue and an enqueue wrap the tail past the end of the ring. The
    // display must then walk across the wrap.
    send_request(cfq_pkg::FN_DEQ, 32'h0);
    send_request(cfq_pkg::FN_ENQ, 32'ha5a5_a5a5);
    send_request(cfq_pkg::FN_DISP, 32'h0);

    // Random part. These phases run with no idling, a mostly idle sender and a
    // mostly stalling receiver. Light idling on both sides follows later.
    run_phase(0, 0, 36);
    run_phase(61, 0, 36);
    run_phase(0, 61, 36);

    // Back-pressure stretch. The receiver holds off while the sender streams
    // with no gaps. The output stage backs up until in_stall rises.
    in_gap_pct = 0;
    out_stall_pct = 0;
    hold_req = 1'b1;
    repeat (14) send_request(cfq_pkg::FN_ENQ, pick_value());
    send_request(cfq_pkg::FN_DISP, pick_value());
    repeat (5) send_request(cfq_pkg::FN_DEQ, pick_value());

    run_phase(15, 15, 36);
    in_valid <= 1'b0;

    // Wait for every expected beat. A beat that never arrives ends the run
    // through the timeout. Afterward, give the block time to show any stray
    // beat.
    while (book.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
